// ----- rtl/damped_wave_column_sim_core_assert.svh -----
// Assertion macros shared by the checker files of the wave column core.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef DAMPED_WAVE_COLUMN_SIM_CORE_ASSERT_SVH
`define DAMPED_WAVE_COLUMN_SIM_CORE_ASSERT_SVH

// same-cycle implication
`define DWCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dwcs assertion failed");

// next-cycle implication
`define DWCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dwcs assertion failed");

`endif

// ----- rtl/dwcs_pkg.sv -----
// Package of the damped wave column core: widths, Q16 factors, codes, states.
// Holds the damping table and the 16-bit saturation helper. No dependencies.
package dwcs_pkg;

  localparam int VelW  = 16;
  localparam int HgtW  = 15;
  localparam int ColW  = 4;
  localparam int StrW  = 12;
  localparam int CalmW = 7;
  localparam int AccW  = 19;
  localparam int KW    = 17;
  localparam int MulQW = 20;
  localparam int SatW  = 20;
  localparam int TotW  = 13;

  localparam logic [KW-1:0] SPREAD_Q16 = 17'd14418;
  localparam logic [KW-1:0] SIDE_Q16   = 17'd29491;

  localparam logic signed [SatW-1:0] HEIGHT_LIMIT = 20'sd7168;
  localparam logic signed [SatW-1:0] HEIGHT_FLOOR = -20'sd7168;
  localparam logic signed [SatW-1:0] VEL_MAX      = 20'sd32767;
  localparam logic signed [SatW-1:0] VEL_MIN      = -20'sd32768;
  localparam logic signed [HgtW-1:0] HEIGHT_OUT_MAX = 15'sd14336;

  localparam logic [CalmW-1:0] CALM_RESET = 7'd30;
  localparam int CalmMax = 100;

  typedef enum logic {
    OP_STEP    = 1'b0,
    OP_DISTURB = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SLOT_LEFT  = 2'd0,
    SLOT_MID   = 2'd1,
    SLOT_RIGHT = 2'd2
  } slot_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_V_RL,
    ST_V_RC,
    ST_V_RR,
    ST_V_LAP,
    ST_V_M1,
    ST_V_ADD,
    ST_V_M2,
    ST_V_WR,
    ST_H_RD,
    ST_H_WR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_O_RD,
    ST_O_WR,
    ST_D_SIDE,
    ST_D_SCAP,
    ST_D_NRD,
    ST_D_NWR,
    ST_D_ARD,
    ST_D_AWR
  } state_t;

  typedef logic [KW-1:0] damp_tbl_t [0:127];

  // Q1.16 damping factor per calm code; codes above 100 act as 100
  function automatic damp_tbl_t build_damp();
    damp_tbl_t t;
    int        c;
    for (int i = 0; i < 128; i++) begin
      c = (i > CalmMax) ? CalmMax : i;
      t[i] = KW'(65536 - (c * 393216 + 5000) / 10000);
    end
    return t;
  endfunction

  function automatic logic signed [VelW-1:0] sat16(input logic signed [SatW-1:0] x);
    logic signed [VelW-1:0] y;
    if (x > VEL_MAX) begin
      y = VelW'(VEL_MAX);
    end else if (x < VEL_MIN) begin
      y = VelW'(VEL_MIN);
    end else begin
      y = VelW'(x);
    end
    return y;
  endfunction

endpackage

// ----- rtl/dwcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dwcs_mul.sv -----
// Shared Q16 multiplier: round(a * k / 65536), halves away from zero, registered.
// Depends on dwcs_pkg.
module dwcs_mul (
  input  logic                                clk,
  input  logic signed [dwcs_pkg::AccW-1:0]    a,
  input  logic        [dwcs_pkg::KW-1:0]      k,
  output logic signed [dwcs_pkg::MulQW-1:0]   q
);

  localparam int PW = dwcs_pkg::AccW + dwcs_pkg::KW;

  logic                               neg;
  logic [dwcs_pkg::AccW-1:0]          mag;
  logic [PW-1:0]                      prod;
  logic [PW-1:0]                      rnd;
  logic [dwcs_pkg::MulQW-1:0]         r;
  logic signed [dwcs_pkg::MulQW-1:0]  q_nxt;
  logic signed [dwcs_pkg::MulQW-1:0]  q_r;

  always_comb begin
    neg   = a[dwcs_pkg::AccW-1];
    mag   = neg ? dwcs_pkg::AccW'(-a) : dwcs_pkg::AccW'(a);
    prod  = PW'(mag) * PW'(k);
    rnd   = prod + PW'(32768);
    r     = rnd[16 +: dwcs_pkg::MulQW];
    q_nxt = neg ? -signed'(r) : signed'(r);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/dwcs_div.sv -----
// Divider by a fixed divisor through a reciprocal multiply, quotient registered in the cycle after start.
// Used for the rounded mean and the disturbance share. No package use.
module dwcs_div #(
  parameter int DIVISOR = 16,
  parameter int DW      = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int Shift = DW + $clog2(DIVISOR);
  localparam int MW    = DW + 1;
  localparam int PW    = DW + MW;
  // ceil(2^Shift / DIVISOR) gives an exact floor for every DW-bit dividend
  localparam longint MultL =
    ((longint'(1) <<< Shift) + longint'(DIVISOR - 1)) / longint'(DIVISOR);
  localparam logic [MW-1:0] Mult = MW'(MultL);

  logic [PW-1:0] prod;
  logic [DW-1:0] quo_r, quo_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    prod     = PW'(dividend) * PW'(Mult);
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = DW'(prod >> Shift);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/damped_wave_column_sim_core.sv -----
// Damped wave column core: NUM_COLUMNS heights and velocities in signed Q4.11,
// a step request (op 0) advances the wave and streams every column out in order,
// a disturb request (op 1) strikes one column and returns nothing. One request
// is worked at a time, in_stall stays high until it is done. A step also holds in_stall
// through any out_stall: the velocity pass reuses one multiplier twice per column, the
// height and output passes go column by column through the one RAM read port, and the
// rounded mean goes through a reciprocal multiply. A disturb skips the missing
// neighbor at an edge column. Calm is written only while idle.
// Depends on dwcs_pkg, dwcs_ram, dwcs_mul, dwcs_div.
module damped_wave_column_sim_core #(
  parameter int NUM_COLUMNS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dwcs_pkg::CalmW-1:0]          cfg_calm,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [0:0]                          in_op,
  input  logic [dwcs_pkg::ColW-1:0]           in_column,
  input  logic [dwcs_pkg::StrW-1:0]           in_strength,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dwcs_pkg::ColW-1:0]           out_column_res,
  output logic signed [dwcs_pkg::HgtW-1:0]    out_height,
  output logic signed [dwcs_pkg::VelW-1:0]    out_velocity,
  output logic                                out_last
);

  localparam int AW       = $clog2(NUM_COLUMNS);
  localparam int SumW     = $clog2(NUM_COLUMNS * 7168 + 1) + 1;
  localparam int DivW     = $clog2(NUM_COLUMNS * 7168 + NUM_COLUMNS);
  localparam int HalfCols = NUM_COLUMNS / 2;
  localparam logic [AW-1:0] LastCol = AW'(NUM_COLUMNS - 1);
  localparam dwcs_pkg::damp_tbl_t DampTbl = dwcs_pkg::build_damp();

  localparam int VW = dwcs_pkg::VelW;
  localparam int SW = dwcs_pkg::SatW;
  localparam int CW = dwcs_pkg::AccW;

  dwcs_pkg::state_t state_r, state_nxt;
  dwcs_pkg::op_t    op_r, op_nxt;
  dwcs_pkg::slot_t  slot_r, slot_nxt, slot_next;

  logic [dwcs_pkg::CalmW-1:0] calm_r, calm_nxt;
  logic [AW-1:0]              col_r, col_nxt;
  logic [AW-1:0]              x_r, x_nxt;
  logic [dwcs_pkg::StrW-1:0]  str_r, str_nxt;
  logic [dwcs_pkg::StrW-1:0]  side_r, side_nxt;
  logic [dwcs_pkg::TotW-1:0]  total_r, total_nxt;
  logic [dwcs_pkg::KW-1:0]    damp_r, damp_nxt;
  logic signed [CW-1:0]       acc_r, acc_nxt;
  logic signed [VW-1:0]       vx_r, vx_nxt;
  logic signed [SumW-1:0]     sum_r, sum_nxt;
  logic signed [VW-1:0]       div_res_r, div_res_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [dwcs_pkg::ColW-1:0]           out_col_r, out_col_nxt;
  logic signed [dwcs_pkg::HgtW-1:0]    out_hgt_r, out_hgt_nxt;
  logic signed [VW-1:0]                out_vel_r, out_vel_nxt;
  logic                                out_last_r, out_last_nxt;

  logic [NUM_COLUMNS-1:0] h_vld_r, h_vld_nxt;
  logic [NUM_COLUMNS-1:0] v_vld_r, v_vld_nxt;
  logic                   h_rvld_r, v_rvld_r;

  logic                 h_we, v_we;
  logic [AW-1:0]        h_waddr, v_waddr, h_raddr, v_raddr;
  logic signed [VW-1:0] h_wdata, v_wdata;
  logic [VW-1:0]        h_rdata, v_rdata;
  logic signed [VW-1:0] h_eff, v_eff;

  logic signed [CW-1:0]             mul_a;
  logic [dwcs_pkg::KW-1:0]          mul_k;
  logic signed [dwcs_pkg::MulQW-1:0] mul_q;

  logic            div_start, div_done;
  logic [DivW-1:0] div_dividend, div_quo;

  logic                 in_acc, out_free, sum_neg, slot_ok;
  logic [AW-1:0]        lft, rgt, nb_addr;
  logic [dwcs_pkg::StrW-1:0] amt;
  logic signed [SW-1:0] amt_s, hs_sum;
  logic signed [SumW-1:0] sum_mag;
  logic signed [VW-1:0] quo16, h_new;

  dwcs_ram #(.WIDTH(VW), .DEPTH(NUM_COLUMNS)) u_hgt_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  dwcs_ram #(.WIDTH(VW), .DEPTH(NUM_COLUMNS)) u_vel_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  dwcs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .k   (mul_k),
    .q   (mul_q)
  );

  dwcs_div #(.DIVISOR(NUM_COLUMNS), .DW(DivW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quo)
  );

  // entries never written read as zero
  assign h_eff = h_rvld_r ? signed'(h_rdata) : '0;
  assign v_eff = v_rvld_r ? signed'(v_rdata) : '0;

  assign in_stall  = (state_r != dwcs_pkg::ST_IDLE);
  assign cfg_ready = (state_r == dwcs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    lft = (x_r == '0) ? '0 : x_r - AW'(1);
    rgt = (x_r == LastCol) ? LastCol : x_r + AW'(1);
    unique case (slot_r)
      dwcs_pkg::SLOT_LEFT:  nb_addr = col_r - AW'(1);
      dwcs_pkg::SLOT_MID:   nb_addr = col_r;
      dwcs_pkg::SLOT_RIGHT: nb_addr = col_r + AW'(1);
      default:              nb_addr = col_r;
    endcase
    unique case (slot_r)
      dwcs_pkg::SLOT_LEFT: slot_next = dwcs_pkg::SLOT_MID;
      default:             slot_next = dwcs_pkg::SLOT_RIGHT;
    endcase
    slot_ok = ((slot_r == dwcs_pkg::SLOT_LEFT) && (col_r != '0)) ||
              (slot_r == dwcs_pkg::SLOT_MID) ||
              ((slot_r == dwcs_pkg::SLOT_RIGHT) && (col_r != LastCol));
    amt     = (slot_r == dwcs_pkg::SLOT_MID) ? str_r : side_r;
    amt_s   = SW'(amt);
    hs_sum  = SW'(h_eff) + SW'(v_eff);
    sum_neg = (op_r == dwcs_pkg::OP_STEP) && sum_r[SumW-1];
    sum_mag = sum_r[SumW-1] ? -sum_r : sum_r;
    quo16   = VW'(div_quo);
    h_new   = h_eff - div_res_r;
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    slot_nxt    = slot_r;
    calm_nxt    = calm_r;
    col_nxt     = col_r;
    x_nxt       = x_r;
    str_nxt     = str_r;
    side_nxt    = side_r;
    total_nxt   = total_r;
    damp_nxt    = damp_r;
    acc_nxt     = acc_r;
    vx_nxt      = vx_r;
    sum_nxt     = sum_r;
    div_res_nxt = div_res_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_col_nxt   = out_col_r;
    out_hgt_nxt   = out_hgt_r;
    out_vel_nxt   = out_vel_r;
    out_last_nxt  = out_last_r;

    h_raddr = x_r;
    v_raddr = x_r;
    h_we    = 1'b0;
    v_we    = 1'b0;
    h_waddr = x_r;
    v_waddr = x_r;
    h_wdata = h_eff;
    v_wdata = v_eff;
    mul_a   = acc_r;
    mul_k   = dwcs_pkg::SPREAD_Q16;

    div_start = 1'b0;
    if (op_r == dwcs_pkg::OP_STEP) begin
      div_dividend = DivW'(unsigned'(sum_mag)) + DivW'(HalfCols);
    end else begin
      div_dividend = DivW'(total_r) + DivW'(HalfCols);
    end

    if (cfg_valid && cfg_ready) begin
      calm_nxt = cfg_calm;
    end

    unique case (state_r)
      dwcs_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = dwcs_pkg::op_t'(in_op);
          col_nxt   = (int'(in_column) >= NUM_COLUMNS) ? LastCol : AW'(in_column);
          str_nxt   = in_strength;
          x_nxt     = '0;
          damp_nxt  = DampTbl[calm_r];
          sum_nxt   = '0;
          total_nxt = '0;
          if (in_op == dwcs_pkg::OP_DISTURB) begin
            state_nxt = dwcs_pkg::ST_D_SIDE;
          end else begin
            state_nxt = dwcs_pkg::ST_V_RL;
          end
        end
      end

      // velocity pass: lap of old heights, spread, damping
      dwcs_pkg::ST_V_RL: begin
        h_raddr   = lft;
        state_nxt = dwcs_pkg::ST_V_RC;
      end
      dwcs_pkg::ST_V_RC: begin
        h_raddr   = x_r;
        acc_nxt   = CW'(h_eff);
        vx_nxt    = v_eff;
        state_nxt = dwcs_pkg::ST_V_RR;
      end
      dwcs_pkg::ST_V_RR: begin
        h_raddr   = rgt;
        acc_nxt   = acc_r - (CW'(h_eff) <<< 1);
        state_nxt = dwcs_pkg::ST_V_LAP;
      end
      dwcs_pkg::ST_V_LAP: begin
        acc_nxt   = acc_r + CW'(h_eff);
        state_nxt = dwcs_pkg::ST_V_M1;
      end
      dwcs_pkg::ST_V_M1: begin
        mul_a     = acc_r;
        mul_k     = dwcs_pkg::SPREAD_Q16;
        state_nxt = dwcs_pkg::ST_V_ADD;
      end
      dwcs_pkg::ST_V_ADD: begin
        acc_nxt   = CW'(dwcs_pkg::sat16(SW'(vx_r) + mul_q));
        state_nxt = dwcs_pkg::ST_V_M2;
      end
      dwcs_pkg::ST_V_M2: begin
        mul_a     = acc_r;
        mul_k     = damp_r;
        state_nxt = dwcs_pkg::ST_V_WR;
      end
      dwcs_pkg::ST_V_WR: begin
        v_we    = 1'b1;
        v_wdata = dwcs_pkg::sat16(mul_q);
        if (x_r == LastCol) begin
          x_nxt     = '0;
          state_nxt = dwcs_pkg::ST_H_RD;
        end else begin
          x_nxt     = x_r + AW'(1);
          state_nxt = dwcs_pkg::ST_V_RL;
        end
      end

      // height pass with clamp and running sum
      dwcs_pkg::ST_H_RD: begin
        state_nxt = dwcs_pkg::ST_H_WR;
      end
      dwcs_pkg::ST_H_WR: begin
        h_we = 1'b1;
        if (hs_sum > dwcs_pkg::HEIGHT_LIMIT) begin
          h_wdata = VW'(dwcs_pkg::HEIGHT_LIMIT);
          v_we    = 1'b1;
          v_wdata = '0;
        end else if (hs_sum < dwcs_pkg::HEIGHT_FLOOR) begin
          h_wdata = VW'(dwcs_pkg::HEIGHT_FLOOR);
          v_we    = 1'b1;
          v_wdata = '0;
        end else begin
          h_wdata = VW'(hs_sum);
        end
        sum_nxt = sum_r + SumW'(h_wdata);
        if (x_r == LastCol) begin
          state_nxt = dwcs_pkg::ST_DIV_GO;
        end else begin
          x_nxt     = x_r + AW'(1);
          state_nxt = dwcs_pkg::ST_H_RD;
        end
      end

      dwcs_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = dwcs_pkg::ST_DIV_WAIT;
      end
      dwcs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          div_res_nxt = sum_neg ? -quo16 : quo16;
          x_nxt       = '0;
          if (op_r == dwcs_pkg::OP_STEP) begin
            state_nxt = dwcs_pkg::ST_O_RD;
          end else begin
            state_nxt = dwcs_pkg::ST_D_ARD;
          end
        end
      end

      // re-center and stream out
      dwcs_pkg::ST_O_RD: begin
        if (out_free) begin
          state_nxt = dwcs_pkg::ST_O_WR;
        end
      end
      dwcs_pkg::ST_O_WR: begin
        h_we          = 1'b1;
        h_wdata       = h_new;
        out_valid_nxt = 1'b1;
        out_col_nxt   = dwcs_pkg::ColW'(x_r);
        out_hgt_nxt   = h_new[dwcs_pkg::HgtW-1:0];
        out_vel_nxt   = v_eff;
        out_last_nxt  = (x_r == LastCol);
        if (x_r == LastCol) begin
          state_nxt = dwcs_pkg::ST_IDLE;
        end else begin
          x_nxt     = x_r + AW'(1);
          state_nxt = dwcs_pkg::ST_O_RD;
        end
      end

      // disturb: side impulse, the struck column and up to two neighbors, then even share
      dwcs_pkg::ST_D_SIDE: begin
        mul_a     = CW'(str_r);
        mul_k     = dwcs_pkg::SIDE_Q16;
        state_nxt = dwcs_pkg::ST_D_SCAP;
      end
      dwcs_pkg::ST_D_SCAP: begin
        side_nxt  = mul_q[dwcs_pkg::StrW-1:0];
        slot_nxt  = dwcs_pkg::SLOT_LEFT;
        state_nxt = dwcs_pkg::ST_D_NRD;
      end
      dwcs_pkg::ST_D_NRD: begin
        v_raddr = nb_addr;
        if (slot_ok) begin
          state_nxt = dwcs_pkg::ST_D_NWR;
        end else if (slot_r == dwcs_pkg::SLOT_RIGHT) begin
          state_nxt = dwcs_pkg::ST_DIV_GO;
        end else begin
          slot_nxt = slot_next;
        end
      end
      dwcs_pkg::ST_D_NWR: begin
        v_we      = 1'b1;
        v_waddr   = nb_addr;
        v_wdata   = dwcs_pkg::sat16(SW'(v_eff) - amt_s);
        total_nxt = total_r + dwcs_pkg::TotW'(amt);
        if (slot_r == dwcs_pkg::SLOT_RIGHT) begin
          state_nxt = dwcs_pkg::ST_DIV_GO;
        end else begin
          slot_nxt  = slot_next;
          state_nxt = dwcs_pkg::ST_D_NRD;
        end
      end
      dwcs_pkg::ST_D_ARD: begin
        state_nxt = dwcs_pkg::ST_D_AWR;
      end
      dwcs_pkg::ST_D_AWR: begin
        v_we    = 1'b1;
        v_wdata = dwcs_pkg::sat16(SW'(v_eff) + SW'(div_res_r));
        if (x_r == LastCol) begin
          state_nxt = dwcs_pkg::ST_IDLE;
        end else begin
          x_nxt     = x_r + AW'(1);
          state_nxt = dwcs_pkg::ST_D_ARD;
        end
      end

      default: begin
        state_nxt = dwcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    h_vld_nxt = h_vld_r;
    v_vld_nxt = v_vld_r;
    if (h_we) begin
      h_vld_nxt[h_waddr] = 1'b1;
    end
    if (v_we) begin
      v_vld_nxt[v_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwcs_pkg::ST_IDLE;
      calm_r      <= dwcs_pkg::CALM_RESET;
      out_valid_r <= 1'b0;
      h_vld_r     <= '0;
      v_vld_r     <= '0;
      h_rvld_r    <= 1'b0;
      v_rvld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      calm_r      <= calm_nxt;
      out_valid_r <= out_valid_nxt;
      h_vld_r     <= h_vld_nxt;
      v_vld_r     <= v_vld_nxt;
      h_rvld_r    <= h_vld_r[h_raddr];
      v_rvld_r    <= v_vld_r[v_raddr];
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    slot_r    <= slot_nxt;
    col_r     <= col_nxt;
    x_r       <= x_nxt;
    str_r     <= str_nxt;
    side_r    <= side_nxt;
    total_r   <= total_nxt;
    damp_r    <= damp_nxt;
    acc_r     <= acc_nxt;
    vx_r      <= vx_nxt;
    sum_r     <= sum_nxt;
    div_res_r <= div_res_nxt;
    out_col_r  <= out_col_nxt;
    out_hgt_r  <= out_hgt_nxt;
    out_vel_r  <= out_vel_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_column_res = out_col_r;
  assign out_height     = out_hgt_r;
  assign out_velocity   = out_vel_r;
  assign out_last       = out_last_r;

endmodule

// ----- rtl/dwcs_checker.sv -----
// Port-level checker for the wave column core, bound to the top level.
// Depends on dwcs_pkg and damped_wave_column_sim_core_assert.svh.
`include "damped_wave_column_sim_core_assert.svh"

module dwcs_checker #(
  parameter int NUM_COLUMNS = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [dwcs_pkg::ColW-1:0]          out_column_res,
  input logic signed [dwcs_pkg::HgtW-1:0]   out_height,
  input logic signed [dwcs_pkg::VelW-1:0]   out_velocity,
  input logic                               out_last
);

  localparam logic [dwcs_pkg::ColW-1:0] LastRes = dwcs_pkg::ColW'(NUM_COLUMNS - 1);
  localparam logic signed [dwcs_pkg::HgtW-1:0] HMax = dwcs_pkg::HEIGHT_OUT_MAX;

  // every accepted request keeps the core busy in the cycle after it is taken
  `DWCS_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `DWCS_ASSERT_IMP(a_last_column, out_valid && out_last, out_column_res == LastRes)
  `DWCS_ASSERT_IMP(a_height_range, out_valid, (out_height <= HMax) && (out_height >= -HMax))
  `DWCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_height) && $stable(out_velocity))

endmodule

bind damped_wave_column_sim_core dwcs_checker #(.NUM_COLUMNS(NUM_COLUMNS)) u_dwcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_column_res (out_column_res),
  .out_height     (out_height),
  .out_velocity   (out_velocity),
  .out_last       (out_last)
);

// ----- tb/tb_damped_wave_column_sim_core.sv -----
// Self-checking testbench for damped_wave_column_sim_core: steps and disturb requests
// go through a Q4.11 ripple predictor and every streamed column is checked in order.
// Depends on dwcs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_damped_wave_column_sim_core;

  localparam int NCOLS        = 16;
  localparam int RUN_LIMIT    = 600000;
  localparam int SETTLE_TICKS = 120;
  localparam int SPREAD_K     = 14418;
  localparam int SIDE_K       = 29491;
  localparam int HGT_CAP      = 7168;

  typedef struct {
    logic [dwcs_pkg::ColW-1:0]        col;
    logic signed [dwcs_pkg::HgtW-1:0] height;
    logic signed [dwcs_pkg::VelW-1:0] vel;
    logic                             last;
  } column_report_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [dwcs_pkg::CalmW-1:0]       cfg_calm;
  logic                             in_valid;
  logic                             in_stall;
  logic [0:0]                       in_op;
  logic [dwcs_pkg::ColW-1:0]        in_column;
  logic [dwcs_pkg::StrW-1:0]        in_strength;
  logic                             out_valid;
  logic                             out_stall;
  logic [dwcs_pkg::ColW-1:0]        out_column_res;
  logic signed [dwcs_pkg::HgtW-1:0] out_height;
  logic signed [dwcs_pkg::VelW-1:0] out_velocity;
  logic                             out_last;

  int surf_height [NCOLS];
  int surf_vel [NCOLS];
  int calm_setting;
  column_report_t pending_columns[$];
  int mismatches;
  int tx_idle_pct;
  int rx_stall_pct;

  damped_wave_column_sim_core #(.NUM_COLUMNS(NCOLS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_calm       (cfg_calm),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_column      (in_column),
    .in_strength    (in_strength),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column_res (out_column_res),
    .out_height     (out_height),
    .out_velocity   (out_velocity),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int clamp_vel(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // round(a * k / 2^16), halves away from zero
  function automatic int scale_q16(input int a, input int k);
    longint mag;
    longint r;
    mag = (a < 0) ? -longint'(a) : longint'(a);
    r = (mag * k + 32768) >>> 16;
    return (a < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic int div_round_cols(input int a);
    int mag;
    int r;
    mag = (a < 0) ? -a : a;
    r = (mag + NCOLS / 2) / NCOLS;
    return (a < 0) ? -r : r;
  endfunction

  task automatic advance_ripple();
    int lap [NCOLS];
    int c;
    int damp;
    int sum;
    int mean;
    int l;
    int r;
    int v;
    int h;
    column_report_t rep;
    c = (calm_setting > 100) ? 100 : calm_setting;
    damp = 65536 - (c * 393216 + 5000) / 10000;
    sum = 0;
    for (int x = 0; x < NCOLS; x++) begin
      l = (x > 0) ? x - 1 : 0;
      r = (x < NCOLS - 1) ? x + 1 : NCOLS - 1;
      lap[x] = surf_height[l] + surf_height[r] - 2 * surf_height[x];
    end
    for (int x = 0; x < NCOLS; x++) begin
      v = clamp_vel(surf_vel[x] + scale_q16(lap[x], SPREAD_K));
      surf_vel[x] = clamp_vel(scale_q16(v, damp));
    end
    for (int x = 0; x < NCOLS; x++) begin
      h = surf_height[x] + surf_vel[x];
      if (h > HGT_CAP) begin
        h = HGT_CAP;
        surf_vel[x] = 0;
      end else if (h < -HGT_CAP) begin
        h = -HGT_CAP;
        surf_vel[x] = 0;
      end
      surf_height[x] = h;
      sum += h;
    end
    mean = div_round_cols(sum);
    for (int x = 0; x < NCOLS; x++) begin
      surf_height[x] -= mean;
      rep.col    = dwcs_pkg::ColW'(x);
      rep.height = dwcs_pkg::HgtW'(surf_height[x]);
      rep.vel    = dwcs_pkg::VelW'(surf_vel[x]);
      rep.last   = (x == NCOLS - 1);
      pending_columns.push_back(rep);
    end
  endtask

  task automatic strike_column(input int col_in, input int strength);
    int col;
    int side;
    int total;
    int share;
    col = (col_in >= NCOLS) ? NCOLS - 1 : col_in;
    side = scale_q16(strength, SIDE_K);
    total = strength;
    surf_vel[col] = clamp_vel(surf_vel[col] - strength);
    if (col > 0) begin
      surf_vel[col - 1] = clamp_vel(surf_vel[col - 1] - side);
      total += side;
    end
    if (col < NCOLS - 1) begin
      surf_vel[col + 1] = clamp_vel(surf_vel[col + 1] - side);
      total += side;
    end
    share = div_round_cols(total);
    for (int x = 0; x < NCOLS; x++) surf_vel[x] = clamp_vel(surf_vel[x] + share);
  endtask

  always @(posedge clk) begin
    out_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    column_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_columns.size() == 0) begin
        $error("column result with nothing pending: column %0d", out_column_res);
        mismatches++;
      end else begin
        want = pending_columns.pop_front();
        if (out_column_res !== want.col) begin
          $error("column_res mismatch: expected %0d, got %0d", want.col, out_column_res);
          mismatches++;
        end
        if (out_height !== want.height) begin
          $error("height mismatch: expected %0d, got %0d", want.height, out_height);
          mismatches++;
        end
        if (out_velocity !== want.vel) begin
          $error("velocity mismatch: expected %0d, got %0d", want.vel, out_velocity);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // leaves in_valid high on acceptance unless an idle gap follows
  task automatic send_request(input dwcs_pkg::op_t op, input int col, input int strength);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_column   <= dwcs_pkg::ColW'(col);
    in_strength <= dwcs_pkg::StrW'(strength);
    do @(posedge clk); while (in_stall);
    if (op == dwcs_pkg::OP_DISTURB) strike_column(col, strength);
    else advance_ripple();
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_columns.size() != 0);
  endtask

  task automatic write_calm(input int value);
    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_calm  <= dwcs_pkg::CalmW'(value);
    do @(posedge clk); while (!cfg_ready);
    calm_setting = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_rest_and_edges();
    send_request(dwcs_pkg::OP_STEP, 0, 0);
    send_request(dwcs_pkg::OP_DISTURB, 0, 4095);
    send_request(dwcs_pkg::OP_DISTURB, NCOLS - 1, 4095);
    send_request(dwcs_pkg::OP_DISTURB, 8, 0);
    repeat (3) send_request(dwcs_pkg::OP_STEP, 0, 0);
    drain_results();
  endtask

  // repeated full strikes drive the velocity to its floor, then heights to the cap
  task automatic test_saturation();
    repeat (11) send_request(dwcs_pkg::OP_DISTURB, 5, 4095);
    repeat (4) send_request(dwcs_pkg::OP_STEP, 0, 0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int calm, input int idle_pct, input int stall_pct,
                                     input int count);
    int str;
    int pick;
    write_calm(calm);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      str = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(4095);
      if ($urandom_range(99) < 55) send_request(dwcs_pkg::OP_STEP, $urandom_range(15), str);
      else send_request(dwcs_pkg::OP_DISTURB, $urandom_range(15), str);
      if ($urandom_range(29) == 0) drain_results();
    end
    drain_results();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    mismatches   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    calm_setting = 30;
    for (int x = 0; x < NCOLS; x++) begin
      surf_height[x] = 0;
      surf_vel[x]    = 0;
    end
    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_calm    <= '0;
    in_valid    <= 1'b0;
    in_op       <= '0;
    in_column   <= '0;
    in_strength <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rest_and_edges();
    test_saturation();
    test_random_traffic(0, 0, 0, 62);
    test_random_traffic(127, 47, 0, 62);
    test_random_traffic(100, 0, 47, 62);
    test_random_traffic($urandom_range(1, 99), 11, 11, 62);

    drain_results();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
